[src/dsasg_pkg.sv]
// shared constants for the dsa signature generator
package dsasg_pkg;

  // width of the configuration register index
  localparam int CFG_IDX_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBGROUP_Q  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_G = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_X   = 8'd3;

  // message hash key, sliced to the datapath width where used
  localparam logic [63:0] HASH_KEY = 64'd1234;

  // register reset values
  localparam logic [63:0] RST_PRIME_P     = 64'd71;
  localparam logic [63:0] RST_SUBGROUP_Q  = 64'd7;
  localparam logic [63:0] RST_GENERATOR_G = 64'd30;
  localparam logic [63:0] RST_PRIVATE_X   = 64'd3;

endpackage

[src/dsasg_in_if.sv]
// input channel: message word and nonce
interface dsasg_in_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] message;
  logic [WIDTH-1:0] nonce_k;

  modport source (output valid, output message, output nonce_k, input ready);
  modport sink (input valid, input message, input nonce_k, output ready);
endinterface

[src/dsasg_out_if.sv]
// result channel: signature pair and bad flag
interface dsasg_out_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] sig_r;
  logic [WIDTH-1:0] sig_s;
  logic             bad_signature;

  modport source (output valid, output sig_r, output sig_s, output bad_signature, input ready);
  modport sink (input valid, input sig_r, input sig_s, input bad_signature, output ready);
endinterface

[src/dsasg_cfg_if.sv]
// configuration write channel
interface dsasg_cfg_if
  import dsasg_pkg::*;
#(parameter int WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WIDTH-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/dsa_signature_generator.sv]
// dsa signature generator top level with shared modular arithmetic unit
//
// One signature per input beat. Reductions, divisions and modular products
// run through one shared unit with a single add, compare and conditional
// subtract: a reduction or a division takes one step per dividend bit, a
// modular product a doubling and an add step per multiplier bit, and every
// operation adds a load and a capture. The exponentiation g^k mod p does a
// square and, for each set bit of k, a multiply over all WIDTH bits of k;
// the inverse of k takes a division and a product per Euclid round; the
// rest is five reductions and two products. The input is not ready until
// the result has been moved into the output register; a finished result
// may wait there while the next beat is taken. Configuration writes are
// always accepted and take effect at once.
module dsa_signature_generator
  import dsasg_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dsasg_in_if.sink    in_ch,
  dsasg_out_if.source out_ch,
  dsasg_cfg_if.sink   cfg_ch
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_GRED    = 4'd1;
  localparam logic [3:0] S_POW_SQ  = 4'd2;
  localparam logic [3:0] S_POW_MUL = 4'd3;
  localparam logic [3:0] S_RRED    = 4'd4;
  localparam logic [3:0] S_KRED    = 4'd5;
  localparam logic [3:0] S_EUC_DIV = 4'd6;
  localparam logic [3:0] S_EUC_MUL = 4'd7;
  localparam logic [3:0] S_HRED    = 4'd8;
  localparam logic [3:0] S_XRED    = 4'd9;
  localparam logic [3:0] S_XR      = 4'd10;
  localparam logic [3:0] S_SIG     = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  // configuration registers
  logic [WIDTH-1:0] p_r, q_r, g_r, x_r;

  // sequencer and working values
  logic [3:0]       state_r;
  logic             run_r;
  logic [CW-1:0]    pbit_r;
  logic [WIDTH-1:0] msg_r, k_r, gb_r, e_r, r_r;
  logic [WIDTH-1:0] r0_r, r1_r, t0_r, t1_r, qt_r, nr_r;
  logic [WIDTH-1:0] hq_r, xq_r, tv_r, s_r;
  logic             ok_r;

  // shared unit
  logic             busy_r, op_r, ph_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] u_a_r, u_b_r, u_m_r, u_acc_r;

  // output register
  logic             out_valid_r;
  logic [WIDTH-1:0] out_r_r, out_s_r;
  logic             out_bad_r;

  // unit step: x = op1 + op2, then one conditional subtract of m
  logic             bitin;
  logic [WIDTH:0]   op1, op2, usum, ured;
  logic             uge, ulast;

  always_comb begin
    bitin = (op_r == OP_DIV) ? u_b_r[WIDTH-1] : 1'b0;
    if (op_r == OP_MUL && ph_r) begin
      op1 = {1'b0, u_acc_r};
      op2 = u_b_r[WIDTH-1] ? {1'b0, u_a_r} : '0;
    end else begin
      op1 = {u_acc_r, bitin};
      op2 = '0;
    end
    usum  = op1 + op2;
    uge   = usum >= {1'b0, u_m_r};
    ured  = uge ? (usum - {1'b0, u_m_r}) : usum;
    ulast = (cnt_r == CNT_LAST) && (op_r == OP_DIV || ph_r);
  end

  // operand selection for the operation of each state
  logic             ld_op, uses_unit, ld_en, fin;
  logic [WIDTH-1:0] ld_a, ld_b, ld_m;

  always_comb begin
    ld_op     = OP_DIV;
    ld_a      = '0;
    ld_b      = '0;
    ld_m      = q_r;
    uses_unit = 1'b1;
    case (state_r)
      S_GRED:    begin ld_b = g_r; ld_m = p_r; end
      S_POW_SQ:  begin ld_op = OP_MUL; ld_a = e_r; ld_b = e_r; ld_m = p_r; end
      S_POW_MUL: begin ld_op = OP_MUL; ld_a = e_r; ld_b = gb_r; ld_m = p_r; end
      S_RRED:    ld_b = e_r;
      S_KRED:    ld_b = k_r;
      S_EUC_DIV: begin ld_b = r0_r; ld_m = r1_r; end
      S_EUC_MUL: begin ld_op = OP_MUL; ld_a = t1_r; ld_b = qt_r; end
      S_HRED:    ld_b = msg_r ^ HASH_KEY[WIDTH-1:0];
      S_XRED:    ld_b = x_r;
      S_XR:      begin ld_op = OP_MUL; ld_a = xq_r; ld_b = r_r; end
      S_SIG:     begin ld_op = OP_MUL; ld_a = t0_r; ld_b = tv_r; end
      default:   uses_unit = 1'b0;
    endcase
    ld_en = uses_unit && !run_r && !(state_r == S_EUC_DIV && r1_r == '0);
    fin   = run_r && !busy_r;
  end

  // combinational helpers at capture
  logic [WIDTH-1:0] nt;
  logic [WIDTH:0]   tsum;
  logic [WIDTH-1:0] tmod;

  always_comb begin
    nt   = (t0_r >= u_acc_r) ? (t0_r - u_acc_r) : (t0_r + (q_r - u_acc_r));
    tsum = {1'b0, hq_r} + {1'b0, u_acc_r};
    tmod = (tsum >= {1'b0, q_r}) ? WIDTH'(tsum - {1'b0, q_r}) : tsum[WIDTH-1:0];
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sig_r = out_r_r;
  assign out_ch.sig_s = out_s_r;
  assign out_ch.bad_signature = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= RST_PRIME_P[WIDTH-1:0];
      q_r <= RST_SUBGROUP_Q[WIDTH-1:0];
      g_r <= RST_GENERATOR_G[WIDTH-1:0];
      x_r <= RST_PRIVATE_X[WIDTH-1:0];
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PRIME_P:     p_r <= cfg_ch.data;
        REG_SUBGROUP_Q:  q_r <= cfg_ch.data;
        REG_GENERATOR_G: g_r <= cfg_ch.data;
        REG_PRIVATE_X:   x_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // shared unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ld_en) begin
      busy_r <= 1'b1;
    end else if (busy_r && ulast) begin
      busy_r <= 1'b0;
    end
    if (ld_en) begin
      op_r    <= ld_op;
      u_a_r   <= ld_a;
      u_b_r   <= ld_b;
      u_m_r   <= ld_m;
      u_acc_r <= '0;
      cnt_r   <= '0;
      ph_r    <= 1'b0;
    end else if (busy_r) begin
      u_acc_r <= ured[WIDTH-1:0];
      if (op_r == OP_DIV) begin
        // quotient bits enter as the dividend bits leave
        u_b_r <= {u_b_r[WIDTH-2:0], uge};
        cnt_r <= cnt_r + 1'b1;
      end else if (!ph_r) begin
        ph_r <= 1'b1;
      end else begin
        ph_r  <= 1'b0;
        u_b_r <= {u_b_r[WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (ld_en) run_r <= 1'b1;
      if (fin) run_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            msg_r <= in_ch.message;
            k_r   <= in_ch.nonce_k;
            s_r   <= '0;
            if (p_r == '0 || q_r == '0) begin
              r_r     <= '0;
              ok_r    <= 1'b0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_GRED;
            end
          end
        end
        S_GRED: if (fin) begin
          gb_r    <= u_acc_r;
          e_r     <= (p_r == WIDTH'(1)) ? '0 : WIDTH'(1);
          pbit_r  <= CNT_LAST;
          state_r <= S_POW_SQ;
        end
        S_POW_SQ: if (fin) begin
          e_r <= u_acc_r;
          if (k_r[pbit_r]) begin
            state_r <= S_POW_MUL;
          end else if (pbit_r == '0) begin
            state_r <= S_RRED;
          end else begin
            pbit_r <= pbit_r - 1'b1;
          end
        end
        S_POW_MUL: if (fin) begin
          e_r <= u_acc_r;
          if (pbit_r == '0) begin
            state_r <= S_RRED;
          end else begin
            pbit_r  <= pbit_r - 1'b1;
            state_r <= S_POW_SQ;
          end
        end
        S_RRED: if (fin) begin
          r_r     <= u_acc_r;
          state_r <= S_KRED;
        end
        S_KRED: if (fin) begin
          r0_r    <= q_r;
          r1_r    <= u_acc_r;
          t0_r    <= '0;
          t1_r    <= (q_r == WIDTH'(1)) ? '0 : WIDTH'(1);
          state_r <= S_EUC_DIV;
        end
        S_EUC_DIV: begin
          if (!run_r && r1_r == '0) begin
            // gcd found: inverse exists only when it is one
            ok_r    <= (r0_r == WIDTH'(1));
            state_r <= (r0_r == WIDTH'(1)) ? S_HRED : S_OUT;
          end else if (fin) begin
            qt_r    <= u_b_r;
            nr_r    <= u_acc_r;
            state_r <= S_EUC_MUL;
          end
        end
        S_EUC_MUL: if (fin) begin
          r0_r    <= r1_r;
          r1_r    <= nr_r;
          t0_r    <= t1_r;
          t1_r    <= nt;
          state_r <= S_EUC_DIV;
        end
        S_HRED: if (fin) begin
          hq_r    <= u_acc_r;
          state_r <= S_XRED;
        end
        S_XRED: if (fin) begin
          xq_r    <= u_acc_r;
          state_r <= S_XR;
        end
        S_XR: if (fin) begin
          tv_r    <= tmod;
          state_r <= S_SIG;
        end
        S_SIG: if (fin) begin
          s_r     <= u_acc_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_r_r     <= r_r;
            out_s_r     <= s_r;
            out_bad_r   <= !ok_r || (r_r == '0) || (s_r == '0);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> run_r)
    else $error("unit busy outside an operation");
  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !run_r)
    else $error("operation pending outside arithmetic states");
  a_unit_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (u_acc_r < u_m_r))
    else $error("unit result not reduced");
  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bad_r) |-> (out_r_r != '0 && out_s_r != '0))
    else $error("good signature with a zero part");
`endif

endmodule

[verif/tb_dsa_signature_generator.sv]
// testbench for the dsa signature generator: predicted signatures checked beat by beat
module tb_dsa_signature_generator;
  import dsasg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam logic [W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [W-1:0] sig_r;
    logic [W-1:0] sig_s;
    logic         bad;
  } signature_t;

  logic clk;
  logic rst_n;

  dsasg_in_if  #(.WIDTH(W)) in_ch ();
  dsasg_out_if #(.WIDTH(W)) out_ch ();
  dsasg_cfg_if #(.WIDTH(W)) cfg_ch ();

  dsa_signature_generator #(.WIDTH(W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // local copy of the key registers
  logic [W-1:0] mod_p, ord_q, gen_g, key_x;

  signature_t sig_queue[$];
  int         mismatches;
  int         burst_left;
  bit         no_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(400_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // extended euclid on k mod q; returns 0 when k has no inverse
  function automatic bit inverse_mod(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, qt, nr, nt, prod;
    r0 = m;
    r1 = a % m;
    t0 = '0;
    t1 = 64'd1 % m;
    while (r1 != 0) begin
      qt = r0 / r1;
      nr = r0 - qt * r1;
      prod = mul_mod(qt, t1, m);
      nt = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    inv = t0;
    return r0 == 64'd1;
  endfunction

  function automatic signature_t sign_word(logic [W-1:0] msg, logic [W-1:0] k);
    signature_t  res;
    logic [63:0] p, q, r, s, kinv, hash, t;
    bit          bad;
    p = 64'(mod_p);
    q = 64'(ord_q);
    res = '0;
    if (p == 0 || q == 0) begin
      res.bad = 1'b1;
      return res;
    end
    hash = {32'd0, msg ^ HASH_KEY[W-1:0]};
    r = pow_mod(64'(gen_g), 64'(k), p) % q;
    s = '0;
    bad = !inverse_mod(64'(k), q, kinv);
    if (!bad) begin
      t = ((hash % q) + mul_mod(64'(key_x), r, q)) % q;
      s = mul_mod(kinv, t, q);
    end
    if (r == 0 || s == 0) bad = 1'b1;
    res.sig_r = r[W-1:0];
    res.sig_s = s[W-1:0];
    res.bad = bad;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    signature_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sig_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat r=%h s=%h bad=%b",
                   out_ch.sig_r, out_ch.sig_s, out_ch.bad_signature);
      end else begin
        want = sig_queue.pop_front();
        if (out_ch.sig_r !== want.sig_r || out_ch.sig_s !== want.sig_s ||
            out_ch.bad_signature !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%h s=%h bad=%b, got r=%h s=%h bad=%b",
                     want.sig_r, want.sig_s, want.bad,
                     out_ch.sig_r, out_ch.sig_s, out_ch.bad_signature);
        end
      end
    end
  end

  // receiver stall pattern: runs of ready, stalls, and long free stretches
  initial begin
    int run;
    out_ch.ready = 1'b0;
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
      end
      if ($urandom_range(0, 5) != 0) begin
        run = $urandom_range(1, 300);
        repeat (run) begin
          @(negedge clk);
          out_ch.ready = 1'b0;
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic [W-1:0] msg, logic [W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = no_gaps ? 0 : $urandom_range(0, 30);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.message = msg;
    in_ch.nonce_k = k;
    do @(posedge clk); while (!in_ch.ready);
    sig_queue.push_back(sign_word(msg, k));
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid = 1'b0;
    while (sig_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PRIME_P:     mod_p = val;
      REG_SUBGROUP_Q:  ord_q = val;
      REG_GENERATOR_G: gen_g = val;
      REG_PRIVATE_X:   key_x = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_keys(logic [W-1:0] p, logic [W-1:0] q, logic [W-1:0] g, logic [W-1:0] x);
    drain();
    write_reg(REG_PRIME_P, p);
    write_reg(REG_SUBGROUP_Q, q);
    write_reg(REG_GENERATOR_G, g);
    write_reg(REG_PRIVATE_X, x);
  endtask

  task automatic test_reset_keys;
    send_item(32'd0, 32'd1);
    send_item(ALL_ONES, 32'd6);
    send_item(32'd1234, 32'd3);
    send_item(32'h5a5a5a5a, 32'd0);
    send_item(32'h0, 32'd7);
    send_item(32'h12345678, 32'd14);
    send_item(32'hdeadbeef, ALL_ONES);
  endtask

  task automatic test_edge_cases;
    set_keys(32'd0, 32'd7, 32'd30, 32'd3);
    send_item(32'h1, 32'd2);
    send_item(ALL_ONES, ALL_ONES);
    set_keys(32'd71, 32'd0, 32'd30, 32'd3);
    send_item(32'h1, 32'd2);
    // unreduced generator and key
    set_keys(32'd71, 32'd7, 32'd101, 32'd45);
    send_item(32'h0, 32'd5);
    send_item(32'h4d2, 32'd21);
    send_item(ALL_ONES, 32'd0);
    // order one and two
    set_keys(32'd23, 32'd1, 32'd4, 32'd1);
    send_item(32'h9, 32'd3);
    set_keys(32'd23, 32'd2, 32'd22, 32'd1);
    send_item(32'h9, 32'd3);
    send_item(32'h8, 32'd4);
    set_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(ALL_ONES, ALL_ONES);
    send_item(32'h0, 32'h8000_0001);
    send_item(32'haaaa_aaaa, 32'h5555_5555);
  endtask

  task automatic random_phase(int n, logic [W-1:0] p, logic [W-1:0] q,
                              logic [W-1:0] g, logic [W-1:0] x);
    logic [W-1:0] k;
    int           pick;
    set_keys(p, q, g, x);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) k = (q > 1) ? $urandom_range(1, q - 1) : 32'd1;
      else if (pick < 18) k = $urandom;
      else if (pick == 18) k = '0;
      else k = q * $urandom_range(1, 5);
      send_item($urandom, k);
    end
  endtask

  task automatic test_random;
    logic [W-1:0] g_big, q_big, p_big;
    p_big = 32'd4294967291;
    q_big = 32'd22605091;
    g_big = W'(pow_mod(64'd2, 64'((p_big - 1) / q_big), 64'(p_big)));
    random_phase(200, 32'd71, 32'd7, 32'd30, 32'd3);
    random_phase(200, 32'd23, 32'd11, 32'd4, 32'd7);
    random_phase(250, 32'd607, 32'd101, 32'd64, 32'd57);
    random_phase(300, p_big, q_big, g_big, $urandom_range(1, q_big - 1));
    random_phase(150, $urandom, $urandom, $urandom, $urandom);
    random_phase(100, ALL_ONES, 32'd65537, $urandom, ALL_ONES);
    random_phase(100, p_big, q_big, $urandom, $urandom);
  endtask

  initial begin
    mismatches = 0;
    burst_left = 0;
    no_gaps = 0;
    mod_p = RST_PRIME_P[W-1:0];
    ord_q = RST_SUBGROUP_Q[W-1:0];
    gen_g = RST_GENERATOR_G[W-1:0];
    key_x = RST_PRIVATE_X[W-1:0];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.message = '0;
    in_ch.nonce_k = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_keys();
    test_edge_cases();
    test_random();
    drain();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && sig_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
